// ===== src/gsp_pkg.sv =====
// shared constants, types and the arctangent table of the gnomonic sky-to-pixel block
// no dependencies; used by the rotator, the divider, the top level and the checker
`default_nettype none

package gsp_pkg;

	// angle format: signed, 2^-20 degree
	localparam int ANG_W = 32;
	localparam logic signed [ANG_W-1:0] ANG_FULL    = 32'sd377487360;
	localparam logic signed [ANG_W-1:0] ANG_HALF    = 32'sd188743680;
	localparam logic signed [ANG_W-1:0] ANG_QUARTER = 32'sd94371840;

	// rotator
	localparam int CORDIC_STAGES = 24;
	localparam int ZW            = 30;
	localparam int CS_W          = 32;
	localparam logic signed [CS_W-1:0] CORDIC_K = 32'sd652032874;
	localparam int CORDIC_LAT    = CORDIC_STAGES + 2;

	// divider
	localparam int NUM_W    = 65;
	localparam int MAG_W    = 33;
	localparam int DIV_STEPS = 34;
	localparam int DIV_LAT  = DIV_STEPS + 1;
	localparam logic [DIV_STEPS-1:0] QUOT_CAP = 34'h2_0000_0000;

	// request in to result out
	localparam int TOTAL_LAT = CORDIC_LAT + DIV_LAT + 7;

	localparam logic signed [31:0] PIX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] PIX_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FAR      = 2'd1,
		ST_ZERO_DEN = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_CENTER_RA    = 3'd0,
		REG_CENTER_DEC   = 3'd1,
		REG_CENTER_X     = 3'd2,
		REG_CENTER_Y     = 3'd3,
		REG_PLANE_RADIUS = 3'd4
	} reg_idx_t;

	// atan(2^-i) in 2^-20 degree
	function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = ZW'(47185920);
			1: r = ZW'(27855475);
			2: r = ZW'(14718068);
			3: r = ZW'(7471121);
			4: r = ZW'(3750058);
			5: r = ZW'(1876857);
			6: r = ZW'(938658);
			7: r = ZW'(469357);
			8: r = ZW'(234682);
			9: r = ZW'(117342);
			10: r = ZW'(58671);
			11: r = ZW'(29335);
			12: r = ZW'(14668);
			13: r = ZW'(7334);
			14: r = ZW'(3667);
			15: r = ZW'(1833);
			16: r = ZW'(917);
			17: r = ZW'(458);
			18: r = ZW'(229);
			19: r = ZW'(115);
			20: r = ZW'(57);
			21: r = ZW'(29);
			22: r = ZW'(14);
			23: r = ZW'(7);
			24: r = ZW'(4);
			25: r = ZW'(2);
			26: r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/gsp_cordic.sv =====
// pipelined sine/cosine rotator, one micro-rotation per register stage
// depends on gsp_pkg
`default_nettype none

module gsp_cordic (
	input  wire logic                               clk,
	input  wire logic signed [gsp_pkg::ANG_W-1:0]   angle,
	output logic signed [gsp_pkg::CS_W-1:0]         sin_val,
	output logic signed [gsp_pkg::CS_W-1:0]         cos_val
);

	localparam int N = gsp_pkg::CORDIC_STAGES;

	logic signed [gsp_pkg::CS_W-1:0] x_s [0:N];
	logic signed [gsp_pkg::CS_W-1:0] y_s [0:N];
	logic signed [gsp_pkg::ZW-1:0]   z_s [0:N];
	logic                            neg_s [0:N];

	logic signed [gsp_pkg::ANG_W-1:0] a_wrap;
	logic signed [gsp_pkg::ANG_W-1:0] a_fold;
	logic                             a_neg;

	// wrap into one turn, then fold into the right half plane
	always_comb begin
		a_wrap = angle;
		if (angle >= gsp_pkg::ANG_HALF) begin
			a_wrap = angle - gsp_pkg::ANG_FULL;
		end else if (angle < -gsp_pkg::ANG_HALF) begin
			a_wrap = angle + gsp_pkg::ANG_FULL;
		end
		a_fold = a_wrap;
		a_neg  = 1'b0;
		if (a_wrap > gsp_pkg::ANG_QUARTER) begin
			a_fold = a_wrap - gsp_pkg::ANG_HALF;
			a_neg  = 1'b1;
		end else if (a_wrap < -gsp_pkg::ANG_QUARTER) begin
			a_fold = a_wrap + gsp_pkg::ANG_HALF;
			a_neg  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= gsp_pkg::CORDIC_K;
		y_s[0]   <= '0;
		z_s[0]   <= gsp_pkg::ZW'(a_fold);
		neg_s[0] <= a_neg;
	end

	for (genvar gi = 0; gi < N; gi++) begin : g_rot
		always_ff @(posedge clk) begin
			if (z_s[gi] >= 0) begin
				x_s[gi+1] <= x_s[gi] - (y_s[gi] >>> gi);
				y_s[gi+1] <= y_s[gi] + (x_s[gi] >>> gi);
				z_s[gi+1] <= z_s[gi] - gsp_pkg::atan_val(gi);
			end else begin
				x_s[gi+1] <= x_s[gi] + (y_s[gi] >>> gi);
				y_s[gi+1] <= y_s[gi] - (x_s[gi] >>> gi);
				z_s[gi+1] <= z_s[gi] + gsp_pkg::atan_val(gi);
			end
			neg_s[gi+1] <= neg_s[gi];
		end
	end

	always_ff @(posedge clk) begin
		sin_val <= neg_s[N] ? -y_s[N] : y_s[N];
		cos_val <= neg_s[N] ? -x_s[N] : x_s[N];
	end

endmodule

`default_nettype wire

// ===== src/gsp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with an overflow precheck
// depends on gsp_pkg
`default_nettype none

module gsp_div (
	input  wire logic                           clk,
	input  wire logic [gsp_pkg::NUM_W-1:0]      num,
	input  wire logic [gsp_pkg::MAG_W-1:0]      dvs,
	output logic [gsp_pkg::DIV_STEPS-1:0]       quot,
	output logic                                over
);

	localparam int S  = gsp_pkg::DIV_STEPS;
	localparam int MW = gsp_pkg::MAG_W;
	localparam int CW = gsp_pkg::MAG_W + S;

	logic [MW-1:0] rem_s  [0:S];
	logic [S-1:0]  w_s    [0:S];
	logic [MW-1:0] d_s    [0:S];
	logic          over_s [0:S];

	// quotient wider than the kept bits: the result gets capped anyway
	always_ff @(posedge clk) begin
		over_s[0] <= CW'(num) >= {dvs, {S{1'b0}}};
		rem_s[0]  <= MW'(num[gsp_pkg::NUM_W-1:S]);
		w_s[0]    <= num[S-1:0];
		d_s[0]    <= dvs;
	end

	for (genvar gi = 0; gi < S; gi++) begin : g_step
		logic [MW:0] trial;
		logic        ge;
		always_comb begin
			trial = {rem_s[gi], w_s[gi][S-1]};
			ge    = trial >= {1'b0, d_s[gi]};
		end
		always_ff @(posedge clk) begin
			rem_s[gi+1]  <= ge ? MW'(trial - {1'b0, d_s[gi]}) : trial[MW-1:0];
			w_s[gi+1]    <= {w_s[gi][S-2:0], ge};
			d_s[gi+1]    <= d_s[gi];
			over_s[gi+1] <= over_s[gi];
		end
	end

	assign quot = w_s[S];
	assign over = over_s[S];

endmodule

`default_nettype wire

// ===== src/gnomonic_sky_to_pixel_top.sv =====
// gnomonic sky-to-pixel projection: top level with config registers and pipeline
// depends on gsp_pkg, gsp_cordic and gsp_div
// requests pass stage 1, the rotators, stages 2-6, the dividers and stage 7 to done
// throughput: one request per cycle; busy is never raised
// the done strobe is high for one cycle per result and cannot be held off
// reset clears the config registers and the valid bits; data stages are not reset
`default_nettype none

module gnomonic_sky_to_pixel_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [28:0]        star_ra,
	input  wire logic signed [27:0] star_dec,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic                    done,
	output logic signed [31:0]      pix_x,
	output logic signed [31:0]      pix_y,
	output logic [1:0]              status
);

	localparam int CS  = gsp_pkg::CS_W;
	localparam int AW  = gsp_pkg::ANG_W;
	localparam int CL  = gsp_pkg::CORDIC_LAT;
	localparam int DL  = gsp_pkg::DIV_LAT;
	localparam int MW  = gsp_pkg::MAG_W;
	localparam int QW  = gsp_pkg::DIV_STEPS;

	// sign and zero flags of the quotient terms, riding along with the divider
	typedef struct packed {
		logic den_zero;
		logic den_neg;
		logic nx_pos;
		logic nx_neg;
		logic ny_pos;
		logic ny_neg;
	} side_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} axis_t;

	// config registers
	logic [28:0]        center_ra_q;
	logic signed [27:0] center_dec_q;
	logic [23:0]        center_x_q;
	logic [23:0]        center_y_q;
	logic [31:0]        plane_radius_q;

	logic accept;

	// stage 1: angle difference
	logic                  v_s1;
	logic signed [AW-1:0]  dra_s1;
	logic signed [AW-1:0]  dec_s1;
	logic signed [AW-1:0]  dec0_s1;
	logic signed [AW-1:0]  diff;

	// rotator outputs
	logic signed [CS-1:0] sd, cd, sd0, cd0, sr, cr;
	logic [CL-1:0]        cv_q;

	// stage 2: first products, Q60
	logic                 v_s2;
	logic signed [63:0]   cdcd0_s2, cdsd0_s2, sdsd0_s2, cdsr_s2, sdcd0_s2;
	logic signed [CS-1:0] cr_s2;

	// stage 3: products with cos(dra)
	logic                 v_s3;
	logic signed [65:0]   tcr_s3, ucr_s3;
	logic signed [63:0]   sdsd0_s3, cdsr_s3, sdcd0_s3;

	// stage 4: denominator and numerators, Q30
	logic                 v_s4;
	logic signed [33:0]   den_s4, nx_s4, ny_s4;
	logic signed [66:0]   den_w, ny_w;
	logic signed [64:0]   nx_w;

	// stage 5: magnitudes and flags
	logic                 v_s5;
	logic [MW-1:0]        mnx_s5, mny_s5, md_s5;
	side_t                side_s5;

	// stage 6: scaled numerators
	logic                      v_s6;
	logic [gsp_pkg::NUM_W-1:0] prx_s6, pry_s6;
	logic [MW-1:0]             md_s6;
	side_t                     side_s6;

	// divider side line
	logic [DL-1:0] dv_q;
	side_t         side_q [0:DL-1];
	logic [QW-1:0] qx, qy;
	logic          ovx, ovy;

	axis_t ax, ay;

	// stage 7: output registers
	logic v_s7;

	// never stalls: every request enters the pipeline
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_ra_q    <= '0;
			center_dec_q   <= '0;
			center_x_q     <= '0;
			center_y_q     <= '0;
			plane_radius_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gsp_pkg::REG_CENTER_RA:    center_ra_q    <= cfg_data[28:0];
				gsp_pkg::REG_CENTER_DEC:   center_dec_q   <= cfg_data[27:0];
				gsp_pkg::REG_CENTER_X:     center_x_q     <= cfg_data[23:0];
				gsp_pkg::REG_CENTER_Y:     center_y_q     <= cfg_data[23:0];
				gsp_pkg::REG_PLANE_RADIUS: plane_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// right ascension difference wrapped once by a full turn
	always_comb begin
		diff = $signed({3'b000, star_ra}) - $signed({3'b000, center_ra_q});
		if (diff >= gsp_pkg::ANG_HALF) begin
			diff = diff - gsp_pkg::ANG_FULL;
		end else if (diff < -gsp_pkg::ANG_HALF) begin
			diff = diff + gsp_pkg::ANG_FULL;
		end
	end

	always_ff @(posedge clk) begin
		dra_s1  <= diff;
		dec_s1  <= AW'(star_dec);
		dec0_s1 <= AW'(center_dec_q);
	end

	// three rotators side by side, same latency
	gsp_cordic u_cor_dec (
		.clk     (clk),
		.angle   (dec_s1),
		.sin_val (sd),
		.cos_val (cd)
	);

	gsp_cordic u_cor_dec0 (
		.clk     (clk),
		.angle   (dec0_s1),
		.sin_val (sd0),
		.cos_val (cd0)
	);

	gsp_cordic u_cor_dra (
		.clk     (clk),
		.angle   (dra_s1),
		.sin_val (sr),
		.cos_val (cr)
	);

	// products; one multiplier per term and stage
	always_ff @(posedge clk) begin
		cdcd0_s2 <= cd * cd0;
		cdsd0_s2 <= cd * sd0;
		sdsd0_s2 <= sd * sd0;
		cdsr_s2  <= cd * sr;
		sdcd0_s2 <= sd * cd0;
		cr_s2    <= cr;

		// t and u back to Q30 before the second product
		tcr_s3   <= 66'(cdcd0_s2 >>> 30) * 66'(cr_s2);
		ucr_s3   <= 66'(cdsd0_s2 >>> 30) * 66'(cr_s2);
		sdsd0_s3 <= sdsd0_s2;
		cdsr_s3  <= cdsr_s2;
		sdcd0_s3 <= sdcd0_s2;
	end

	// shift back to Q30, rounding toward minus infinity
	always_comb begin
		den_w = 67'(sdsd0_s3) + 67'(tcr_s3);
		nx_w  = -65'(cdsr_s3);
		ny_w  = 67'(sdcd0_s3) - 67'(ucr_s3);
	end

	always_ff @(posedge clk) begin
		den_s4 <= 34'(den_w >>> 30);
		nx_s4  <= 34'(nx_w >>> 30);
		ny_s4  <= 34'(ny_w >>> 30);

		mnx_s5 <= nx_s4[33] ? MW'(-nx_s4) : MW'(nx_s4);
		mny_s5 <= ny_s4[33] ? MW'(-ny_s4) : MW'(ny_s4);
		md_s5  <= den_s4[33] ? MW'(-den_s4) : MW'(den_s4);
		side_s5.den_zero <= den_s4 == '0;
		side_s5.den_neg  <= den_s4[33];
		side_s5.nx_pos   <= !nx_s4[33] && nx_s4 != '0;
		side_s5.nx_neg   <= nx_s4[33];
		side_s5.ny_pos   <= !ny_s4[33] && ny_s4 != '0;
		side_s5.ny_neg   <= ny_s4[33];

		// radius times numerator magnitude, 32 by 33 bits
		prx_s6  <= gsp_pkg::NUM_W'(plane_radius_q) * gsp_pkg::NUM_W'(mnx_s5);
		pry_s6  <= gsp_pkg::NUM_W'(plane_radius_q) * gsp_pkg::NUM_W'(mny_s5);
		md_s6   <= md_s5;
		side_s6 <= side_s5;
	end

	// both axes share the denominator magnitude
	gsp_div u_div_x (
		.clk  (clk),
		.num  (prx_s6),
		.dvs  (md_s6),
		.quot (qx),
		.over (ovx)
	);

	gsp_div u_div_y (
		.clk  (clk),
		.num  (pry_s6),
		.dvs  (md_s6),
		.quot (qy),
		.over (ovy)
	);

	always_ff @(posedge clk) begin
		side_q[0] <= side_s6;
		for (int i = 1; i < DL; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// valid bits follow the data through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			cv_q <= '0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			dv_q <= '0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			cv_q <= {cv_q[CL-2:0], v_s1};
			v_s2 <= cv_q[CL-1];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			dv_q <= {dv_q[DL-2:0], v_s6};
			v_s7 <= dv_q[DL-1];
		end
	end

	// cap the quotient, apply the sign, add the centre and clamp, or rail at a zero denominator
	function automatic axis_t axis_out(
		input logic [23:0] ctr,
		input logic [QW-1:0] q,
		input logic ovf,
		input logic npos,
		input logic nneg,
		input logic dneg,
		input logic dzero
	);
		logic [QW-1:0]      qc;
		logic signed [35:0] sum;
		axis_t              r;
		qc = (ovf || q > gsp_pkg::QUOT_CAP) ? gsp_pkg::QUOT_CAP : q;
		if (nneg != dneg) begin
			sum = $signed({12'd0, ctr}) - $signed({2'b00, qc});
		end else begin
			sum = $signed({12'd0, ctr}) + $signed({2'b00, qc});
		end
		r.sat = 1'b0;
		if (dzero) begin
			// point at infinity: rail in the numerator's direction, or the centre if it is zero
			if (npos) begin
				r.val = gsp_pkg::PIX_MAX;
			end else if (nneg) begin
				r.val = gsp_pkg::PIX_MIN;
			end else begin
				r.val = $signed({8'd0, ctr});
			end
		end else if (sum > 36'sd2147483647) begin
			r.val = gsp_pkg::PIX_MAX;
			r.sat = 1'b1;
		end else if (sum < -36'sd2147483648) begin
			r.val = gsp_pkg::PIX_MIN;
			r.sat = 1'b1;
		end else begin
			r.val = sum[31:0];
		end
		return r;
	endfunction

	always_comb begin
		ax = axis_out(center_x_q, qx, ovx, side_q[DL-1].nx_pos, side_q[DL-1].nx_neg,
			side_q[DL-1].den_neg, side_q[DL-1].den_zero);
		ay = axis_out(center_y_q, qy, ovy, side_q[DL-1].ny_pos, side_q[DL-1].ny_neg,
			side_q[DL-1].den_neg, side_q[DL-1].den_zero);
	end

	always_ff @(posedge clk) begin
		if (dv_q[DL-1]) begin
			pix_x <= ax.val;
			pix_y <= ay.val;
			if (side_q[DL-1].den_zero) begin
				status <= gsp_pkg::ST_ZERO_DEN;
			end else if (ax.sat || ay.sat) begin
				status <= gsp_pkg::ST_SAT;
			end else if (side_q[DL-1].den_neg) begin
				status <= gsp_pkg::ST_FAR;
			end else begin
				status <= gsp_pkg::ST_OK;
			end
		end
	end

	assign done = v_s7;

endmodule

`default_nettype wire

// ===== src/gsp_checker.sv =====
// port-level checks of the gnomonic sky-to-pixel top level, with its bind
// depends on gsp_pkg and gnomonic_sky_to_pixel_top
`default_nettype none

module gsp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [31:0] pix_x,
	input wire logic signed [31:0] pix_y,
	input wire logic [1:0]         status
);

	// the pipeline never refuses a request
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every request gives a result after the fixed latency
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(gsp_pkg::TOTAL_LAT) done)
		else $error("result missing");

	// no result without a request
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, gsp_pkg::TOTAL_LAT))
		else $error("spurious result");

	// saturated status comes with a clamped pixel
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == gsp_pkg::ST_SAT) |->
		(pix_x == gsp_pkg::PIX_MAX || pix_x == gsp_pkg::PIX_MIN ||
		 pix_y == gsp_pkg::PIX_MAX || pix_y == gsp_pkg::PIX_MIN))
		else $error("saturated status without clamp");

endmodule

bind gnomonic_sky_to_pixel_top gsp_checker u_gsp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.pix_x  (pix_x),
	.pix_y  (pix_y),
	.status (status)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the gnomonic sky-to-pixel projection top level
// depends on gsp_pkg and gnomonic_sky_to_pixel_top; carries its own fixed-point predictor
`timescale 1ns / 1ps

module testbench;

	localparam longint FULL_TURN = 377487360;
	localparam longint HALF_TURN = 188743680;
	localparam longint QUARTER_TURN = 94371840;
	localparam longint ROT_GAIN = 652032874;
	localparam int WATCHDOG_LIMIT = 20000;

	// projected pixel expected for one request
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		gsp_pkg::status_t st;
	} pixel_t;

	// holds expected pixels in request order and compares results against them
	class pixel_scoreboard;
		pixel_t pending[$];
		int n_checked;
		int n_errors;

		function void note_request(pixel_t p);
			pending.push_back(p);
		endfunction

		task check_result(logic signed [31:0] x, logic signed [31:0] y,
				logic [1:0] st);
			pixel_t e;
			if (pending.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (x !== e.x)
				report_mismatch($sformatf("pix_x %0d expected %0d", x, e.x));
			if (y !== e.y)
				report_mismatch($sformatf("pix_y %0d expected %0d", y, e.y));
			if (st !== e.st)
				report_mismatch($sformatf("status %0d expected %0d", st, e.st));
		endtask

		task report_mismatch(string msg);
			n_errors++;
			if (n_errors <= 40)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [28:0] star_ra;
	logic signed [27:0] star_dec;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic done;
	logic signed [31:0] pix_x;
	logic signed [31:0] pix_y;
	logic [1:0] status;

	gnomonic_sky_to_pixel_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.star_ra(star_ra), .star_dec(star_dec),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pix_x(pix_x), .pix_y(pix_y), .status(status)
	);

	pixel_scoreboard board;

	// predictor's own copy of the registers
	longint unsigned ctr_ra, ctr_x, ctr_y, radius;
	longint ctr_dec;
	int n_requests;
	int idle_cycles;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// arithmetic shift right, rounding toward minus infinity
	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	// one full turn folded into [-180, 180)
	function automatic longint wrap_turn(longint a);
		if (a >= HALF_TURN)
			return a - FULL_TURN;
		if (a < -HALF_TURN)
			return a + FULL_TURN;
		return a;
	endfunction

	// rotator: sine and cosine in Q30 of an angle in 2^-20 degree
	function automatic void rotate(longint a, output longint sn, output longint cs);
		bit flip;
		longint x, y, z, dx, dy;
		flip = 0;
		x = ROT_GAIN;
		y = 0;
		a = wrap_turn(a);
		if (a > QUARTER_TURN) begin
			a -= HALF_TURN;
			flip = 1;
		end else if (a < -QUARTER_TURN) begin
			a += HALF_TURN;
			flip = 1;
		end
		z = a;
		for (int i = 0; i < gsp_pkg::CORDIC_STAGES; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(gsp_pkg::atan_val(i));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(gsp_pkg::atan_val(i));
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endfunction

	// centre plus the scaled quotient, clamped to 32 bits
	function automatic longint place_on_axis(longint c, longint num, longint den,
			inout bit sat);
		longint unsigned mn, md, q;
		longint v;
		mn = num < 0 ? -num : num;
		md = den < 0 ? -den : den;
		q = (radius * mn) / md;
		if (q > 64'h2_0000_0000)
			q = 64'h2_0000_0000;
		v = ((num < 0) != (den < 0)) ? c - longint'(q) : c + longint'(q);
		if (v > 64'sh7FFF_FFFF) begin
			sat = 1;
			return 64'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			sat = 1;
			return -64'sh8000_0000;
		end
		return v;
	endfunction

	function automatic pixel_t project_star(logic [28:0] ra, logic signed [27:0] dec);
		longint sd, cd, sd0, cd0, sr, cr, t, u, den, nx, ny, px, py;
		bit sat;
		pixel_t p;
		sat = 0;
		rotate(longint'(dec), sd, cd);
		rotate(ctr_dec, sd0, cd0);
		rotate(wrap_turn(longint'(ra) - longint'(ctr_ra)), sr, cr);
		t = shr(cd * cd0, 30);
		u = shr(cd * sd0, 30);
		den = shr(sd * sd0 + t * cr, 30);
		nx = shr(-(cd * sr), 30);
		ny = shr(sd * cd0 - u * cr, 30);
		if (den == 0) begin
			px = nx > 0 ? 64'sh7FFF_FFFF : (nx < 0 ? -64'sh8000_0000 : longint'(ctr_x));
			py = ny > 0 ? 64'sh7FFF_FFFF : (ny < 0 ? -64'sh8000_0000 : longint'(ctr_y));
			p.st = gsp_pkg::ST_ZERO_DEN;
		end else begin
			px = place_on_axis(longint'(ctr_x), nx, den, sat);
			py = place_on_axis(longint'(ctr_y), ny, den, sat);
			p.st = sat ? gsp_pkg::ST_SAT : (den < 0 ? gsp_pkg::ST_FAR : gsp_pkg::ST_OK);
		end
		p.x = px[31:0];
		p.y = py[31:0];
		return p;
	endfunction

	// mostly short gaps, now and then a long one, often none
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 60));
	endfunction

	task automatic write_reg(gsp_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gsp_pkg::REG_CENTER_RA: ctr_ra = val[28:0];
			gsp_pkg::REG_CENTER_DEC: ctr_dec = longint'($signed(val[27:0]));
			gsp_pkg::REG_CENTER_X: ctr_x = val[23:0];
			gsp_pkg::REG_CENTER_Y: ctr_y = val[23:0];
			gsp_pkg::REG_PLANE_RADIUS: radius = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_unknown_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one request; start stays high across back-to-back requests
	task automatic send_star(logic [28:0] ra, logic signed [27:0] dec, bit gaps);
		int n;
		n = 0;
		start <= 1'b1;
		star_ra <= ra;
		star_dec <= dec;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(project_star(ra, dec));
		n_requests++;
		if (gaps && $urandom_range(0, 3) == 0)
			n = gap_length();
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (gsp_pkg::TOTAL_LAT + 8) @(posedge clk);
	endtask

	function automatic logic signed [27:0] any_dec(bit wild);
		if (wild)
			return 28'($urandom());
		return 28'($urandom_range(0, 2 * QUARTER_TURN) - QUARTER_TURN);
	endfunction

	// results are sampled at the edge that ends the strobe cycle
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(pix_x, pix_y, status);
	end

	// watchdog: cycles with neither a request nor a result taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", board.pending.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		logic [28:0] near_ra;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		star_ra = '0;
		star_dec = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ctr_ra = 0;
		ctr_dec = 0;
		ctr_x = 0;
		ctr_y = 0;
		radius = 0;
		n_requests = 0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: radius zero gives the centre except at a zero denominator
		send_star(29'd0, 28'sd0, 0);
		send_star(29'd94371840, 28'sd0, 0);
		drain();

		// typical centre, then extreme inputs
		write_reg(gsp_pkg::REG_CENTER_RA, 32'd50000000);
		write_reg(gsp_pkg::REG_CENTER_DEC, 32'd30000000);
		write_reg(gsp_pkg::REG_CENTER_X, 32'd2000 << 8);
		write_reg(gsp_pkg::REG_CENTER_Y, 32'd1500 << 8);
		write_reg(gsp_pkg::REG_PLANE_RADIUS, 32'd3000 << 8);
		write_unknown_reg(3'd5, 32'hFFFF_FFFF);
		write_unknown_reg(3'd7, 32'h1234_5678);
		send_star(29'd50000000, 28'sd30000000, 0);       // centre itself
		send_star(29'd50100000, 28'sd30050000, 0);       // close by
		send_star(29'd0, -28'sd94371840, 0);             // extremes of the range
		send_star(29'd377487359, 28'sd94371840, 0);
		send_star(29'h1FFF_FFFF, 28'sh7FF_FFFF, 0);      // out of range angles
		send_star(29'd0, 28'sh800_0000, 0);
		send_star(29'd50000000 + 29'd94371840, 28'sd0, 0);  // near the horizon
		send_star(29'd50000000 + 29'd188743680, -28'sd30000000, 0);  // antipode
		send_star(29'd60000000, 28'sd35000000, 0);
		drain();

		// pole centre, zero denominators on the equator
		write_reg(gsp_pkg::REG_CENTER_DEC, 32'd94371840);
		write_reg(gsp_pkg::REG_CENTER_RA, 32'd0);
		write_reg(gsp_pkg::REG_PLANE_RADIUS, 32'hFFFF_FFFF);
		write_reg(gsp_pkg::REG_CENTER_X, 32'hFF_FFFF);
		write_reg(gsp_pkg::REG_CENTER_Y, 32'd0);
		send_star(29'd0, 28'sd0, 0);
		send_star(29'd10000000, 28'sd1, 0);
		send_star(29'd10000000, -28'sd50000000, 0);
		send_star(29'd20000000, 28'sd90000000, 0);
		drain();

		// random phases over several register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(gsp_pkg::REG_CENTER_DEC, -32'sd94371840);
					write_reg(gsp_pkg::REG_CENTER_RA, 32'd377487359);
					write_reg(gsp_pkg::REG_PLANE_RADIUS, 32'd0);
				end
				1: begin
					write_reg(gsp_pkg::REG_CENTER_DEC, 32'd0);
					write_reg(gsp_pkg::REG_PLANE_RADIUS, 32'd1);
				end
				default: begin
					write_reg(gsp_pkg::REG_CENTER_RA, $urandom_range(0, 377487359));
					write_reg(gsp_pkg::REG_CENTER_DEC,
						$urandom_range(0, 188743680) - 94371840);
					write_reg(gsp_pkg::REG_PLANE_RADIUS, ph == 7 ? $urandom() :
						$urandom_range(1 << 12, 1 << 22));
				end
			endcase
			write_reg(gsp_pkg::REG_CENTER_X, $urandom_range(0, 24'hFF_FFFF));
			write_reg(gsp_pkg::REG_CENTER_Y, $urandom_range(0, 24'hFF_FFFF));
			for (int k = 0; k < 125; k++) begin
				// mostly near the centre, some anywhere, a few with raw bits
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						near_ra = 29'((ctr_ra + $urandom_range(0, 4000000) + 377487360
							- 2000000) % 377487360);
						send_star(near_ra,
							28'(ctr_dec + $urandom_range(0, 4000000) - 2000000), 1);
					end
					6, 7, 8: send_star(29'($urandom_range(0, 377487359)), any_dec(0), 1);
					default: send_star(29'($urandom()), any_dec(1), 1);
				endcase
			end
			drain();
		end

		$display("covered %0d requests, %0d results checked, over eight random settings",
			n_requests, board.n_checked);
		if (board.n_errors == 0 && board.pending.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
src/gsp_pkg.sv
src/gsp_cordic.sv
src/gsp_div.sv
src/gnomonic_sky_to_pixel_top.sv
src/gsp_checker.sv
bench/testbench.sv
